// ===== rtl/core/sorted_key_set_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted key set assertion macros
// Shared concurrent assertion forms for the sorted key set checkers.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_ASSERT_SVH
`define SORTED_KEY_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SKS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/skc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key set package
// Operation codes, default sizes and cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

    // Default sizes
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_KEY_WIDTH = 16;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_kind_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic do_insert;
        logic do_delete;
    } cell_ctl_t;

    // Compare status from a cell
    typedef struct packed {
        logic lt;   // cell holds a key below the request key
        logic eq;   // cell holds the request key
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/skc_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key, compares it against the broadcast request key and shifts
// toward or away from its neighbors on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_cell #(
    parameter int KEY_WIDTH = skc_pkg::DEF_KEY_WIDTH
) (
    input  wire logic                   aclk,
    input  wire skc_pkg::cell_ctl_t     ctl_i,
    input  wire logic [KEY_WIDTH-1:0]   bkey_i,
    input  wire logic                   occ_i,
    input  wire logic                   lt_prev_i,
    input  wire logic [KEY_WIDTH-1:0]   key_left_i,
    input  wire logic [KEY_WIDTH-1:0]   key_right_i,
    output logic      [KEY_WIDTH-1:0]   key_o,
    output skc_pkg::cell_stat_t         stat_o
);
    import skc_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 lt;

    // Compare own key against the request key
    assign lt        = occ_i && ($signed(key_reg) < $signed(bkey_i));
    assign stat_o.lt = lt;
    assign stat_o.eq = occ_i && (key_reg == bkey_i);
    assign key_o     = key_reg;

    // Hold below the insertion point, otherwise take the new key or shift
    always_comb begin
        key_next = key_reg;
        if (ctl_i.do_insert && !lt) begin
            key_next = lt_prev_i ? bkey_i : key_left_i;
        end else if (ctl_i.do_delete && !lt) begin
            key_next = key_right_i;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_set.sv =====
// ----------------------------------------------------------------------------
// Sorted key set
// A row of CAPACITY cells keeps distinct signed keys in ascending order and
// serves insert, delete and lookup requests. One request is accepted per
// clock: every cell compares the broadcast key with its own and shifts in
// the same cycle, so throughput is one request per cycle and the result
// appears in the output register in the cycle after acceptance. A stalled
// result stops acceptance only while the output register is held.
// s_tuser carries the operation (0 insert, 1 delete, 2 lookup, 3 no-op).
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set #(
    parameter int CAPACITY  = skc_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = skc_pkg::DEF_KEY_WIDTH,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int S_W      = ((KEY_WIDTH + 7) / 8) * 8,
    localparam int M_W      = ((CW + 3 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [S_W-1:0] s_tdata,   // key
    input  wire logic [1:0]     s_tuser,   // kind
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [M_W-1:0] m_tdata    // success, full_res, element_count, is_empty
);
    import skc_pkg::*;

    logic                 accept;
    logic [KEY_WIDTH-1:0] bkey;
    op_kind_t             kind;
    cell_ctl_t            ctl;
    cell_stat_t           stat [CAPACITY];
    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]  eq_vec;
    logic                 present;
    logic                 room;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 valid_reg;
    logic                 success_reg;
    logic                 success_next;
    logic                 full_reg;
    logic                 full_next;
    logic [CW-1:0]        ocount_reg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !valid_reg || m_tready;
    assign bkey     = s_tdata[KEY_WIDTH-1:0];
    assign kind     = op_kind_t'(s_tuser);
    assign room     = count_reg < CW'(CAPACITY);

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                 lt_prev;
        logic [KEY_WIDTH-1:0] key_left;
        logic [KEY_WIDTH-1:0] key_right;

        if (i == 0) begin : g_first
            assign lt_prev  = 1'b1;
            assign key_left = cell_key[0];
        end else begin : g_mid
            assign lt_prev  = stat[i-1].lt;
            assign key_left = cell_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign key_right = cell_key[i];
        end else begin : g_inner
            assign key_right = cell_key[i+1];
        end

        assign eq_vec[i] = stat[i].eq;

        skc_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctl_i       (ctl),
            .bkey_i      (bkey),
            .occ_i       (CW'(i) < count_reg),
            .lt_prev_i   (lt_prev),
            .key_left_i  (key_left),
            .key_right_i (key_right),
            .key_o       (cell_key[i]),
            .stat_o      (stat[i])
        );
    end

    assign present = |eq_vec;

    // Decode the request into cell control, result and new count
    always_comb begin
        ctl          = '0;
        success_next = 1'b0;
        full_next    = 1'b0;
        count_next   = count_reg;
        if (accept) begin
            case (kind)
                OP_INSERT: begin
                    if (!present && room) begin
                        ctl.do_insert = 1'b1;
                        success_next  = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end else if (!present) begin
                        full_next = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (present) begin
                        ctl.do_delete = 1'b1;
                        success_next  = 1'b1;
                        count_next    = count_reg - CW'(1);
                    end
                end
                OP_LOOKUP: begin
                    success_next = present;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance count and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register on acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            success_reg <= success_next;
            full_reg    <= full_next;
            ocount_reg  <= count_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_W'({(ocount_reg == '0), ocount_reg, full_reg, success_reg});

endmodule

`default_nettype wire

// ===== rtl/core/skc_check.sv =====
// ----------------------------------------------------------------------------
// Sorted key set port checker
// Watches the top level ports for consistent results and a held output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_set_assert.svh"

module skc_check #(
    parameter int CAPACITY  = skc_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = skc_pkg::DEF_KEY_WIDTH,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int S_W      = ((KEY_WIDTH + 7) / 8) * 8,
    localparam int M_W      = ((CW + 3 + 7) / 8) * 8
) (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_tvalid,
    input wire logic           s_tready,
    input wire logic [S_W-1:0] s_tdata,
    input wire logic [1:0]     s_tuser,
    input wire logic           m_tvalid,
    input wire logic           m_tready,
    input wire logic [M_W-1:0] m_tdata
);
    logic [CW-1:0] count;
    logic          req_seen;

    assign count    = m_tdata[CW+1:2];
    assign req_seen = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    // Hold a stalled result
    `SKS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    // Empty flag matches the count
    `SKS_ASSERT_SAME(a_empty, aclk, aresetn, m_tvalid, m_tdata[CW+2] == (count == '0), "empty flag disagrees with count")
    // A refused insert never reports success
    `SKS_ASSERT_SAME(a_full, aclk, aresetn, m_tvalid, !(m_tdata[0] && m_tdata[1]), "full and success both set")
    // Count never exceeds capacity
    `SKS_ASSERT_SAME(a_cap, aclk, aresetn, m_tvalid, count <= CW'(CAPACITY), "count above capacity")
    // An accepted request always yields a result next cycle
    `SKS_ASSERT_NEXT(a_result, aclk, aresetn, req_seen, m_tvalid, "accepted request gave no result")

endmodule

bind sorted_key_set skc_check #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
) u_skc_check (.*);

`default_nettype wire
